>>> rtl/core/mwcrc_pkg.sv
// shared types, register indexes and constants of the multi-width crc engine
package mwcrc_pkg;

	// register file geometry
	localparam int unsigned NumRegs   = 3;
	localparam int unsigned AddrWidth = 4;
	localparam int unsigned DataWidth = 32;

	// register indexes
	localparam logic [1:0] RegWidthMode  = 2'd0;
	localparam logic [1:0] RegPolynomial = 2'd1;
	localparam logic [1:0] RegInitValue  = 2'd2;

	// reset values
	localparam logic [1:0]  WidthModeReset  = 2'd0;
	localparam logic [15:0] PolynomialReset = 16'h0007;
	localparam logic [31:0] InitValueReset  = 32'h0000_0000;

	// width mode codes; bit 1 alone selects the reflected crc32 path
	localparam logic [1:0] ModeCrc8  = 2'd0;
	localparam logic [1:0] ModeCrc16 = 2'd1;

	// fixed reflected crc32 generator
	localparam logic [31:0] ReflectedPoly32Default = 32'hEDB8_8320;

	// msb of the crc8 and crc16 registers
	localparam logic [7:0]  Crc8Msb  = 8'h80;
	localparam logic [15:0] Crc16Msb = 16'h8000;

	// configuration seen by the datapath
	typedef struct packed {
		logic [1:0]  width_mode;
		logic [15:0] polynomial;
		logic [31:0] init_value;
	} cfg_t;

	// result of one byte update
	typedef struct packed {
		logic [31:0] crc_next;
		logic [31:0] crc_value;
		logic        crc_is_zero;
	} step_res_t;

endpackage

>>> rtl/core/mwcrc_regs.sv
// apb configuration registers of the multi-width crc engine
module mwcrc_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [mwcrc_pkg::AddrWidth-1:0]     paddr,
	input  logic [mwcrc_pkg::DataWidth-1:0]     pwdata,
	output logic [mwcrc_pkg::DataWidth-1:0]     prdata,
	output logic                                pready,
	output mwcrc_pkg::cfg_t                     cfg
);

	logic [1:0]  width_mode_q;
	logic [15:0] polynomial_q;
	logic [31:0] init_value_q;
	logic        wr_en;
	logic [1:0]  reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];

	// register writes on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_mode_q <= mwcrc_pkg::WidthModeReset;
			polynomial_q <= mwcrc_pkg::PolynomialReset;
			init_value_q <= mwcrc_pkg::InitValueReset;
		end else if (wr_en) begin
			unique case (reg_idx)
				mwcrc_pkg::RegWidthMode:  width_mode_q <= pwdata[1:0];
				mwcrc_pkg::RegPolynomial: polynomial_q <= pwdata[15:0];
				mwcrc_pkg::RegInitValue:  init_value_q <= pwdata;
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (reg_idx)
			mwcrc_pkg::RegWidthMode:  prdata = {30'd0, width_mode_q};
			mwcrc_pkg::RegPolynomial: prdata = {16'd0, polynomial_q};
			mwcrc_pkg::RegInitValue:  prdata = init_value_q;
			default:                  prdata = '0;
		endcase
	end

	assign cfg.width_mode = width_mode_q;
	assign cfg.polynomial = polynomial_q;
	assign cfg.init_value = init_value_q;

endmodule

>>> rtl/core/mwcrc_step.sv
// one-byte crc update for the crc8, crc16 and reflected crc32 modes
module mwcrc_step #(
	parameter logic [31:0] REFLECTED_POLY_32 = mwcrc_pkg::ReflectedPoly32Default
) (
	input  mwcrc_pkg::cfg_t        cfg,
	input  logic [31:0]            crc_cur,
	input  logic [7:0]             data_byte,
	input  logic                   first_byte,
	output mwcrc_pkg::step_res_t   res
);

	logic [7:0]  c8;
	logic [15:0] c16;
	logic [31:0] c32;
	logic [31:0] stored;
	logic [31:0] shown;

	// crc8, msb first
	always_comb begin
		c8 = (first_byte ? cfg.init_value[7:0] : crc_cur[7:0]) ^ data_byte;
		for (int b = 0; b < 8; b++) begin
			if ((c8 & mwcrc_pkg::Crc8Msb) != 8'd0)
				c8 = (c8 << 1) ^ cfg.polynomial[7:0];
			else
				c8 = c8 << 1;
		end
	end

	// crc16, msb first
	always_comb begin
		c16 = (first_byte ? cfg.init_value[15:0] : crc_cur[15:0]) ^ {data_byte, 8'd0};
		for (int b = 0; b < 8; b++) begin
			if ((c16 & mwcrc_pkg::Crc16Msb) != 16'd0)
				c16 = (c16 << 1) ^ cfg.polynomial;
			else
				c16 = c16 << 1;
		end
	end

	// crc32, reflected, inverted start
	always_comb begin
		c32 = (first_byte ? ~cfg.init_value : crc_cur) ^ {24'd0, data_byte};
		for (int b = 0; b < 8; b++) begin
			if (c32[0])
				c32 = (c32 >> 1) ^ REFLECTED_POLY_32;
			else
				c32 = c32 >> 1;
		end
	end

	// mode select; stored value masked to the mode width
	always_comb begin
		priority if (cfg.width_mode[1]) begin
			stored = c32;
			shown  = ~c32;
		end else if (cfg.width_mode == mwcrc_pkg::ModeCrc16) begin
			stored = {16'd0, c16};
			shown  = {16'd0, c16};
		end else begin
			stored = {24'd0, c8};
			shown  = {24'd0, c8};
		end
	end

	assign res.crc_next    = stored;
	assign res.crc_value   = shown;
	assign res.crc_is_zero = (shown == 32'd0);

endmodule

>>> rtl/core/multi_width_crc_engine_core.sv
// top level of the multi-width crc engine
// Byte-stream CRC engine: one message byte per transaction in, one result per
// byte out, carrying the running CRC in final form, a zero flag for verify and
// a copy of the last-byte marker. Modes: crc8 and crc16 msb-first with the
// programmed polynomial and init value, crc32 reflected with a fixed generator
// (inverted start and output); width_mode 3 acts as crc32. A byte passes from
// acceptance to result through an input register, then the eight-bit
// unrolled XOR update into the result register and the CRC register. A new
// byte is taken every cycle while results are drained; the CRC register feeds
// back into the update. Program registers only with no byte in flight.
module multi_width_crc_engine_core #(
	parameter logic [31:0] REFLECTED_POLY_32 = mwcrc_pkg::ReflectedPoly32Default
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// apb configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [mwcrc_pkg::AddrWidth-1:0]     paddr,
	input  logic [mwcrc_pkg::DataWidth-1:0]     pwdata,
	output logic [mwcrc_pkg::DataWidth-1:0]     prdata,
	output logic                                pready,
	// byte input channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [7:0]                          data_byte,
	input  logic                                first_byte,
	input  logic                                last_byte,
	// result channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [31:0]                         crc_value,
	output logic                                crc_is_zero,
	output logic                                message_end
);

	mwcrc_pkg::cfg_t      cfg;
	mwcrc_pkg::step_res_t res;

	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        first_s1;
	logic        last_s1;
	logic        valid_s2;
	logic [31:0] crc_value_s2;
	logic        crc_is_zero_s2;
	logic        message_end_s2;
	logic [31:0] crc_q;
	logic        advance;

	mwcrc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mwcrc_step #(
		.REFLECTED_POLY_32 (REFLECTED_POLY_32)
	) u_step (
		.cfg        (cfg),
		.crc_cur    (crc_q),
		.data_byte  (data_s1),
		.first_byte (first_s1),
		.res        (res)
	);

	// handshake: stage 1 moves on when the result slot is free or draining
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1  <= data_byte;
			first_s1 <= first_byte;
			last_s1  <= last_byte;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			crc_value_s2   <= res.crc_value;
			crc_is_zero_s2 <= res.crc_is_zero;
			message_end_s2 <= last_s1;
		end
	end

	// running crc register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= 32'd0;
		end else if (advance) begin
			crc_q <= res.crc_next;
		end
	end

	assign out_valid   = valid_s2;
	assign crc_value   = crc_value_s2;
	assign crc_is_zero = crc_is_zero_s2;
	assign message_end = message_end_s2;

	// zero flag agrees with the value it describes
	a_zero_flag: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (crc_is_zero_s2 == (crc_value_s2 == 32'd0)))
		else $error("crc_is_zero disagrees with crc_value");

	// msb-first modes leave the upper crc bits clear
	a_crc_mask: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !cfg.width_mode[1]) |=> (crc_q[31:16] == 16'd0))
		else $error("crc register not masked in msb-first mode");

	// a held byte in stage 1 blocks new input
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |-> !in_ready)
		else $error("input accepted over a stalled byte");

	// a result only appears after a byte sat in stage 1
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s2) |-> $past(valid_s1))
		else $error("result produced without a byte");

endmodule
